@@ rtl/tlvd_pkg.sv @@
// Shared types and constants for the TLV record deframer.
package tlvd_pkg;

	localparam logic [15:0] HEADER_BYTES = 16'd6;
	localparam logic [15:0] PREAMBLE_BYTES = 16'd3;

	localparam logic [2:0] CL_HDR = 3'd0;
	localparam logic [2:0] CL_CAT = 3'd1;
	localparam logic [2:0] CL_PAR = 3'd2;
	localparam logic [2:0] CL_LEN = 3'd3;
	localparam logic [2:0] CL_PAY = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CAT    = 3'd1,
		PH_PAR    = 3'd2,
		PH_LENHI  = 3'd3,
		PH_LENLO  = 3'd4,
		PH_PAY    = 3'd5
	} tlvd_phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} tlvd_in_t;

	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  data_value;
		logic [7:0]  category;
		logic [7:0]  parameter_res;
		logic [15:0] record_length;
		logic [15:0] payload_offset;
		logic        record_end;
		logic        header_ok;
		logic        file_end;
		logic        checksum_ok;
		logic        truncated;
	} tlvd_out_t;

	function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h4B;
			2'd1: v = 8'h4E;
			2'd2: v = 8'h47;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/tlvd_core.sv @@
// Parse state and per-byte result logic of the TLV record deframer.
module tlvd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  tlvd_pkg::tlvd_in_t beat,
	output tlvd_pkg::tlvd_out_t res
);
	import tlvd_pkg::*;

	tlvd_phase_t phase_q, phase_n;
	logic [15:0] pos_q, pos_n;
	logic [7:0]  cat_q, cat_n;
	logic [7:0]  par_q, par_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  sum_q, sum_n;
	logic        pm_q, pm_n;

	logic [15:0] hdr_inc;
	logic [16:0] pay_inc;
	logic [2:0]  cls;
	logic [15:0] offset;
	logic        rend;
	logic        hok;

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		cat_n   = cat_q;
		par_n   = par_q;
		len_n   = len_q;
		pm_n    = pm_q;
		sum_n   = sum_q + beat.in_byte;
		cls     = CL_HDR;
		offset  = 16'd0;
		rend    = 1'b0;
		hdr_inc = pos_q + 16'd1;
		pay_inc = {1'b0, pos_q} + 17'd1;
		case (phase_q)
			PH_HEADER: begin
				cls = CL_HDR;
				if (pos_q < PREAMBLE_BYTES && beat.in_byte != preamble_byte(pos_q[1:0])) begin
					pm_n = 1'b0;
				end
				pos_n = hdr_inc;
				if (hdr_inc >= HEADER_BYTES) begin
					phase_n = PH_CAT;
					pos_n   = 16'd0;
				end
			end
			PH_CAT: begin
				cls     = CL_CAT;
				cat_n   = beat.in_byte;
				par_n   = 8'd0;
				len_n   = 16'd0;
				phase_n = PH_PAR;
			end
			PH_PAR: begin
				cls     = CL_PAR;
				par_n   = beat.in_byte;
				phase_n = PH_LENHI;
			end
			PH_LENHI: begin
				cls     = CL_LEN;
				len_n   = {beat.in_byte, 8'd0};
				phase_n = PH_LENLO;
			end
			PH_LENLO: begin
				cls   = CL_LEN;
				len_n = {len_q[15:8], beat.in_byte};
				pos_n = 16'd0;
				if ({len_q[15:8], beat.in_byte} == 16'd0) begin
					rend    = 1'b1;
					phase_n = PH_CAT;
				end else begin
					phase_n = PH_PAY;
				end
			end
			PH_PAY: begin
				cls    = CL_PAY;
				offset = pos_q;
				if (pay_inc >= {1'b0, len_q}) begin
					rend    = 1'b1;
					phase_n = PH_CAT;
					pos_n   = 16'd0;
				end else begin
					pos_n = pay_inc[15:0];
				end
			end
			default: begin
				cls     = CL_HDR;
				phase_n = PH_HEADER;
			end
		endcase
		hok = pm_n && (phase_n != PH_HEADER || pos_n >= PREAMBLE_BYTES);
	end

	always_comb begin
		res.byte_class     = cls;
		res.data_value     = beat.in_byte;
		res.category       = cat_n;
		res.parameter_res  = par_n;
		res.record_length  = len_n;
		res.payload_offset = offset;
		res.record_end     = rend;
		res.header_ok      = hok;
		res.file_end       = beat.last_byte;
		res.checksum_ok    = beat.last_byte && (sum_n == 8'd0);
		res.truncated      = beat.last_byte && (phase_n != PH_CAT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 16'd0;
			cat_q   <= 8'd0;
			par_q   <= 8'd0;
			len_q   <= 16'd0;
			sum_q   <= 8'd0;
			pm_q    <= 1'b1;
		end else if (fire) begin
			if (beat.last_byte) begin
				phase_q <= PH_HEADER;
				pos_q   <= 16'd0;
				cat_q   <= 8'd0;
				par_q   <= 8'd0;
				len_q   <= 16'd0;
				sum_q   <= 8'd0;
				pm_q    <= 1'b1;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				cat_q   <= cat_n;
				par_q   <= par_n;
				len_q   <= len_n;
				sum_q   <= sum_n;
				pm_q    <= pm_n;
			end
		end
	end

endmodule

@@ rtl/tlv_record_deframer.sv @@
// Top level of the TLV record deframer: input stage, parser, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------
//  bytes   | byte_valid| byte_stall| byte_beat (tlvd_in_t)
//  results | rec_valid | rec_stall | rec_beat  (tlvd_out_t)
//
// One byte per clock sustained while no result is stalled; each byte goes from the
// input stage through the combinational parse update into the result register.
// arst_n clears the parse state and both valid flags; the next byte starts a new file.
// A stalled result holds; the input stage still fills, then byte_stall rises.
module tlv_record_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  tlvd_pkg::tlvd_in_t  byte_beat,
	output logic                rec_valid,
	input  logic                rec_stall,
	output tlvd_pkg::tlvd_out_t rec_beat
);
	import tlvd_pkg::*;

	logic      valid_s1;
	tlvd_in_t  beat_s1;
	logic      valid_s2;
	tlvd_out_t beat_s2;
	tlvd_out_t res;
	logic      adv;
	logic      fire;

	assign adv        = !(valid_s2 && rec_stall);
	assign fire       = adv && valid_s1;
	assign byte_stall = valid_s1 && !adv;

	tlvd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1 <= byte_beat;
		end
		if (fire) begin
			beat_s2 <= res;
		end
	end

	assign rec_valid = valid_s2;
	assign rec_beat  = beat_s2;

endmodule

@@ rtl/tlvd_checker.sv @@
// Port-level checks for the TLV record deframer, bound to the top level.
module tlvd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rec_valid,
	input logic                rec_stall,
	input tlvd_pkg::tlvd_out_t rec_beat
);
	import tlvd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(rec_beat))
		else $error("stalled result changed");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> rec_beat.byte_class <= CL_PAY)
		else $error("bad byte class");

	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_beat.file_end |-> !rec_beat.checksum_ok && !rec_beat.truncated)
		else $error("end status outside file end");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_beat.byte_class != CL_PAY |-> rec_beat.payload_offset == 16'd0)
		else $error("offset on non-payload beat");

	a_rend: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_beat.record_end |->
			rec_beat.byte_class == CL_PAY || rec_beat.byte_class == CL_LEN)
		else $error("record end on wrong class");

endmodule

bind tlv_record_deframer tlvd_checker u_tlvd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (rec_valid),
	.rec_stall (rec_stall),
	.rec_beat  (rec_beat)
);
